// ===== rtl/core/lsfp_pkg.sv =====
// package: request kinds, protocol constants and the decoded request type for the lcd framer
`timescale 1ns / 1ps

package lsfp_pkg;

    // request kinds carried in the cmd field
    typedef enum logic [1:0] {
        CMD_COMMAND   = 2'd0,
        CMD_DATA      = 2'd1,
        CMD_TEXT_ADDR = 2'd2,
        CMD_PLOT      = 2'd3
    } t_cmd;

    // serial protocol bytes
    localparam logic [7:0] SYNC_CMD    = 8'hF8;
    localparam logic [7:0] SYNC_DAT    = 8'hFA;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;

    // controller instructions
    localparam logic [7:0] INS_EXT_MODE   = 8'h34;
    localparam logic [7:0] INS_GFX_ON     = 8'h36;
    localparam logic [7:0] INS_BASIC_MODE = 8'h30;
    localparam logic [7:0] ADDR_BASE      = 8'h80;

    // text row base addresses, rows 1..4
    localparam logic [7:0] ROW_BASE_1 = 8'h80;
    localparam logic [7:0] ROW_BASE_2 = 8'h90;
    localparam logic [7:0] ROW_BASE_3 = 8'h88;
    localparam logic [7:0] ROW_BASE_4 = 8'h98;

    // most writes one request can cause
    localparam int MAX_WRITES = 7;
    localparam int WIDX_W     = $clog2(MAX_WRITES);

    // byte position inside one three-byte write
    typedef enum logic [1:0] {
        POS_SYNC = 2'd0,
        POS_HIGH = 2'd1,
        POS_LOW  = 2'd2
    } t_pos;

    // one decoded request: the list of writes to send
    typedef struct packed {
        logic [MAX_WRITES-1:0][7:0] val;
        logic [MAX_WRITES-1:0]      dat;
        logic [WIDX_W-1:0]          nwr;
    } t_req;

endpackage

// ===== rtl/core/lsfp_decode.sv =====
// request decoder: maps one input word onto its list of controller writes
`timescale 1ns / 1ps

module lsfp_decode import lsfp_pkg::*; (
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_coord_a,
    input  logic [5:0] i_coord_b,
    output t_req       o_req
);

    logic [7:0]  row_base;
    logic        row_ok;
    logic [7:0]  text_addr;
    logic [15:0] pix_word;
    logic [3:0]  x_bit;
    logic [2:0]  x_word;
    logic        y_half;
    logic [4:0]  y_row;

    // text row base lookup, rows outside 1..4 emit nothing
    always_comb begin
        row_ok   = 1'b1;
        row_base = ROW_BASE_1;
        case (i_coord_a)
            7'd1: begin
                row_base = ROW_BASE_1;
            end
            7'd2: begin
                row_base = ROW_BASE_2;
            end
            7'd3: begin
                row_base = ROW_BASE_3;
            end
            7'd4: begin
                row_base = ROW_BASE_4;
            end
            default: begin
                row_ok = 1'b0;
            end
        endcase
    end

    // column 1 maps onto the base, 8-bit wrap for anything else
    assign text_addr = row_base + {2'b00, i_coord_b} - 8'd1;

    // plot addressing pieces
    assign x_bit    = i_coord_a[3:0];
    assign x_word   = i_coord_a[6:4];
    assign y_half   = i_coord_b[5];
    assign y_row    = i_coord_b[4:0];
    assign pix_word = 16'h8000 >> x_bit;

    // write list per request kind
    always_comb begin
        o_req.val = '0;
        o_req.dat = '0;
        o_req.nwr = '0;
        case (t_cmd'(i_cmd))
            CMD_COMMAND: begin
                o_req.val[0] = i_byte_value;
                o_req.nwr    = WIDX_W'(1);
            end
            CMD_DATA: begin
                o_req.val[0] = i_byte_value;
                o_req.dat[0] = 1'b1;
                o_req.nwr    = WIDX_W'(1);
            end
            CMD_TEXT_ADDR: begin
                o_req.val[0] = text_addr;
                o_req.nwr    = row_ok ? WIDX_W'(1) : '0;
            end
            CMD_PLOT: begin
                o_req.val[0] = INS_EXT_MODE;
                o_req.val[1] = ADDR_BASE | {3'b000, y_row};
                o_req.val[2] = ADDR_BASE | {4'b0000, y_half, x_word};
                o_req.val[3] = pix_word[15:8];
                o_req.val[4] = pix_word[7:0];
                o_req.val[5] = INS_GFX_ON;
                o_req.val[6] = INS_BASIC_MODE;
                o_req.dat[3] = 1'b1;
                o_req.dat[4] = 1'b1;
                o_req.nwr    = WIDX_W'(MAX_WRITES);
            end
            default: begin
                o_req.nwr = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lsfp_emit.sv =====
// byte emitter: walks the held write list and drives the output register
`timescale 1ns / 1ps

module lsfp_emit import lsfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_front_valid,
    input  t_req       i_front,
    output logic       o_load,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // out_byte[7:0]
    output logic       o_m_axis_tlast
);

    t_req              r_cur;
    logic              r_busy;
    logic [WIDX_W-1:0] r_widx;
    t_pos              r_pos;
    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_olast;

    t_pos              n_pos;
    logic              out_free;
    logic              step;
    logic              is_last;
    logic [7:0]        cur_val;
    logic              cur_dat;
    logic [7:0]        cur_byte;

    assign out_free = !r_ovalid || i_m_axis_tready;
    assign step     = r_busy && out_free;
    assign cur_val  = r_cur.val[r_widx];
    assign cur_dat  = r_cur.dat[r_widx];
    assign is_last  = (r_pos == POS_LOW) && (r_widx == r_cur.nwr - WIDX_W'(1));
    assign o_load   = !r_busy || (step && is_last);

    // byte of the current write
    always_comb begin
        n_pos    = POS_SYNC;
        cur_byte = cur_dat ? SYNC_DAT : SYNC_CMD;
        case (r_pos)
            POS_SYNC: begin
                cur_byte = cur_dat ? SYNC_DAT : SYNC_CMD;
                n_pos    = POS_HIGH;
            end
            POS_HIGH: begin
                cur_byte = cur_val & NIBBLE_MASK;
                n_pos    = POS_LOW;
            end
            POS_LOW: begin
                cur_byte = {cur_val[3:0], 4'b0000};
                n_pos    = POS_SYNC;
            end
            default: begin
                cur_byte = cur_dat ? SYNC_DAT : SYNC_CMD;
                n_pos    = POS_SYNC;
            end
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_widx <= '0;
            r_pos  <= POS_SYNC;
        end else if (o_load) begin
            r_busy <= i_front_valid;
            r_widx <= '0;
            r_pos  <= POS_SYNC;
        end else if (step) begin
            r_pos <= n_pos;
            if (r_pos == POS_LOW) begin
                r_widx <= r_widx + WIDX_W'(1);
            end
        end
    end

    // current request payload
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_cur <= i_front;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_obyte <= cur_byte;
            r_olast <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ===== rtl/core/lcd_serial_frame_plotter.sv =====
// top level: serial lcd write framer, request in, protocol bytes out
// path: input register with the decoded word, emitter request register, byte output register.
// throughput: one byte per cycle while the output is ready; 3 bytes per command, data or text address
// request, 21 bytes per plot request, set by the single byte output register.
// a text address request with a bad row is accepted and dropped, and emits nothing.
// reset: synchronous active low; clears the held request and the output valid.
`timescale 1ns / 1ps

module lcd_serial_frame_plotter import lsfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // cmd[1:0], byte_value[9:2], coord_a[16:10],
                                         // coord_b[22:17], zero pad[23]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_byte[7:0]
    output logic        o_m_axis_tlast
);

    t_req r_front;
    logic r_fvalid;
    t_req dec_req;
    logic load;
    logic accept;

    // decode the incoming word
    lsfp_decode u_decode (
        .i_cmd        (i_s_axis_tdata[1:0]),
        .i_byte_value (i_s_axis_tdata[9:2]),
        .i_coord_a    (i_s_axis_tdata[16:10]),
        .i_coord_b    (i_s_axis_tdata[22:17]),
        .o_req        (dec_req)
    );

    assign o_s_axis_tready = !r_fvalid || load;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // input register holding the next decoded request, empty lists are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else begin
            r_fvalid <= (r_fvalid && !load) || (accept && (dec_req.nwr != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_front <= dec_req;
        end
    end

    // byte emitter
    lsfp_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_front_valid   (r_fvalid),
        .i_front         (r_front),
        .o_load          (load),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
